### hw/rtl/sacu_pkg.sv
// sacu_pkg: shared types, register indexes and the overlay color function
// for the segmentation argmax colorizer; depends on nothing
`default_nettype none

package sacu_pkg;

    // configuration register indexes
    localparam int unsigned CfgAddrW = 3;
    localparam logic [CfgAddrW-1:0] REG_MODE        = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_NUM_CLASSES = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_BACKGROUND  = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_ALPHA       = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_THRESHOLD   = 3'd4;

    localparam logic MODE_SCORE = 1'b0;
    localparam logic MODE_ID    = 1'b1;

    localparam logic [31:0] CLASS0_COLOR = 32'h00ff_0000;
    localparam int unsigned AlphaShift   = 24;

    // argmax status for the item in the input register
    typedef struct packed {
        logic       close;   // this score ends the pixel
        logic       valid;   // a class qualified and it is within 0..255
        logic [7:0] cls;     // winning class, low byte
    } argmax_res_t;

    // bit-interleaved palette: class bit 3g+ch lands at bit (7-g) of byte (3-ch)
    function automatic logic [31:0] voc_color(input logic [7:0] cls);
        logic [31:0] c;
        c = '0;
        for (int g = 0; g < 3; g++) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (3 * g + ch < 8) begin
                    c[(7 - g) + 8 * (3 - ch)] = cls[3 * g + ch];
                end
            end
        end
        return c;
    endfunction

    function automatic logic [31:0] colorize(
        input logic       valid,
        input logic [7:0] cls,
        input logic [9:0] bg,
        input logic [7:0] alpha
    );
        logic [31:0] color;
        logic        is_bg;
        is_bg = (bg[9:8] == 2'b00) && (bg[7:0] == cls);
        if (!valid || is_bg) begin
            return '0;
        end
        if (cls == 8'd0) begin
            color = (bg != 10'd0) ? CLASS0_COLOR : '0;
        end else begin
            color = voc_color(cls);
        end
        return color | ({24'd0, alpha} << AlphaShift);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/sacu_argmax.sv
// sacu_argmax: per-pixel running argmax over class scores
// depends on sacu_pkg
`default_nettype none

module sacu_argmax #(
    parameter int unsigned MAX_CLASSES = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     clear,      // drop the pixel in progress
    input  wire logic                     step,       // consume the held score
    input  wire logic [31:0]              value,
    input  wire logic [31:0]              threshold,
    input  wire logic [$clog2(MAX_CLASSES)-1:0] last_idx,
    output sacu_pkg::argmax_res_t         res
);
    import sacu_pkg::*;

    localparam int unsigned CW = $clog2(MAX_CLASSES);

    logic [31:0]   best_score_reg, best_score_next;
    logic [CW-1:0] best_class_reg, best_class_next;
    logic          best_found_reg, best_found_next;
    logic [CW-1:0] counter_reg, counter_next;

    logic          gt;
    logic          found_now;
    logic [CW-1:0] class_now;
    logic [CW+7:0] class_ext;

    always_comb begin
        gt        = $signed(value) > $signed(best_found_reg ? best_score_reg : threshold);
        found_now = best_found_reg | gt;
        class_now = gt ? counter_reg : best_class_reg;
        class_ext = {8'd0, class_now};
        res.close = counter_reg >= last_idx;
        res.valid = found_now && (class_ext <= (CW + 8)'(255));
        res.cls   = class_ext[7:0];
    end

    always_comb begin
        best_score_next = best_score_reg;
        best_class_next = best_class_reg;
        best_found_next = best_found_reg;
        counter_next    = counter_reg;
        if (clear) begin
            best_score_next = '0;
            best_class_next = '0;
            best_found_next = 1'b0;
            counter_next    = '0;
        end else if (step) begin
            if (res.close) begin
                best_score_next = '0;
                best_class_next = '0;
                best_found_next = 1'b0;
                counter_next    = '0;
            end else begin
                if (gt) begin
                    best_score_next = value;
                end
                best_class_next = class_now;
                best_found_next = found_now;
                counter_next    = counter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_score_reg <= '0;
            best_class_reg <= '0;
            best_found_reg <= 1'b0;
            counter_reg    <= '0;
        end else begin
            best_score_reg <= best_score_next;
            best_class_reg <= best_class_next;
            best_found_reg <= best_found_next;
            counter_reg    <= counter_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/segmentation_argmax_colorizer_unit.sv
// segmentation_argmax_colorizer_unit: top level, stream ports, config registers,
// input and result registers; depends on sacu_pkg and sacu_argmax
`default_nettype none

// Turns segmentation network output into RGBA overlay pixels. In score mode
// (mode = 0) the block takes num_classes signed Q16.16 scores per pixel in class
// order and keeps the class with the highest score above the threshold, the
// earliest on a tie; the last score of the pixel produces one pixel word, the
// others produce nothing. In id mode (mode = 1) every request is a class id and
// produces one pixel word. A word is zero for no qualifying class, the
// background class, or a class outside 0..255; else the bit-interleaved palette
// color (a fixed color for class 0) in bits 8..31 ORed with alpha_level at bit
// 24. Rate: one request per cycle unless the result stream stalls; a request
// passes the input register, then the result register. The running argmax
// compare and update sets the cycle. Writing mode or num_classes drops a pixel
// in progress. Configure only while no request is in flight.
module segmentation_argmax_colorizer_unit #(
    parameter int unsigned MAX_CLASSES = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [sacu_pkg::CfgAddrW-1:0] cfg_addr,
    input  wire logic [31:0] cfg_wr_data,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,    // [31:0] value (signed)
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata     // [31:0] pixel_rgba
);
    import sacu_pkg::*;

    localparam int unsigned CW = $clog2(MAX_CLASSES);
    localparam logic [31:0] MaxClasses32 = 32'(MAX_CLASSES);

    // configuration registers
    logic          mode_reg;
    logic [CW-1:0] last_idx_reg;      // clamped num_classes minus one
    logic [9:0]    background_reg;
    logic [7:0]    alpha_reg;
    logic [31:0]   threshold_reg;
    logic [31:0]   nc32;
    logic [31:0]   last_idx32;

    // input register
    logic          s1_valid_reg, s1_valid_next;
    logic [31:0]   s1_value_reg;

    // result register
    logic          m_valid_reg, m_valid_next;
    logic [31:0]   m_data_reg, m_data_next;

    logic          clear_pixel;
    logic          out_free;
    logic          s1_has_result;
    logic          s1_fire;
    logic          s_fire;
    argmax_res_t   am_res;
    logic          px_valid;
    logic [7:0]    px_class;

    // clamp num_classes into 1..MAX_CLASSES and keep its last index
    always_comb begin
        nc32 = {21'd0, cfg_wr_data[10:0]};
        if (nc32 == 32'd0) begin
            last_idx32 = 32'd0;
        end else if (nc32 > MaxClasses32) begin
            last_idx32 = MaxClasses32 - 32'd1;
        end else begin
            last_idx32 = nc32 - 32'd1;
        end
    end

    assign clear_pixel = cfg_wr_en && ((cfg_addr == REG_MODE) || (cfg_addr == REG_NUM_CLASSES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_SCORE;
            last_idx_reg   <= '0;
            background_reg <= '0;
            alpha_reg      <= 8'hff;
            threshold_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MODE:        mode_reg       <= cfg_wr_data[0];
                REG_NUM_CLASSES: last_idx_reg   <= last_idx32[CW-1:0];
                REG_BACKGROUND:  background_reg <= cfg_wr_data[9:0];
                REG_ALPHA:       alpha_reg      <= cfg_wr_data[7:0];
                REG_THRESHOLD:   threshold_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // running argmax; state moves when a score-mode request leaves the input register
    sacu_argmax #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_argmax (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (clear_pixel),
        .step      (s1_fire && (mode_reg == MODE_SCORE)),
        .value     (s1_value_reg),
        .threshold (threshold_reg),
        .last_idx  (last_idx_reg),
        .res       (am_res)
    );

    // handshake: the input register drains when its request makes no result
    // or the result register can take one
    always_comb begin
        out_free      = !m_valid_reg || m_tready;
        s1_has_result = (mode_reg == MODE_ID) || am_res.close;
        s1_fire       = s1_valid_reg && (!s1_has_result || out_free);
        s_tready      = !s1_valid_reg || s1_fire;
        s_fire        = s_tvalid && s_tready;
        s1_valid_next = s_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
    end

    // pixel word selection
    always_comb begin
        if (mode_reg == MODE_ID) begin
            px_valid = (s1_value_reg[31:8] == 24'd0);   // id in 0..255
            px_class = s1_value_reg[7:0];
        end else begin
            px_valid = am_res.valid;
            px_class = am_res.cls;
        end
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (s1_fire && s1_has_result) begin
            m_valid_next = 1'b1;
            m_data_next  = colorize(px_valid, px_class, background_reg, alpha_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_value_reg <= s_tdata;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // an empty input register always takes a request
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_tready)
        else $error("input register empty but not ready");

    // every id-mode request that leaves the input register shows up as a result
    a_id_makes_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && (mode_reg == MODE_ID) && !clear_pixel) |=> m_valid_reg)
        else $error("id-mode request lost");

    // a new result only comes from a held request
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_valid_reg))
        else $error("result without a request");

endmodule

`default_nettype wire
